// ===== hw/rtl/rar_pkg.sv =====
package rar_pkg;

  localparam int ValueBits = 62;
  localparam int NumW      = ValueBits + 1;
  localparam int DenW      = ValueBits;
  localparam int WordW     = 64;
  localparam int WideW     = 128;
  localparam int NumHighW  = 61;
  localparam int DenHighW  = 60;

  typedef struct packed {
    logic             neg;
    logic [WideW-1:0] mag;
  } sm_t;

  // signed-magnitude add; equal magnitudes with opposite signs keep the first sign
  function automatic sm_t add_sm(input logic sx, input logic [WideW-1:0] x,
                                 input logic sy, input logic [WideW-1:0] y);
    sm_t r;
    if (sx == sy) begin
      r.neg = sx;
      r.mag = x + y;
    end else if (x >= y) begin
      r.neg = sx;
      r.mag = x - y;
    end else begin
      r.neg = sy;
      r.mag = y - x;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rar_div.sv =====
module rar_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rar_pkg::WideW-1:0] dividend_i,
  input  logic [rar_pkg::DenW-1:0]  divisor_i,
  output logic                     done_o,
  output logic [rar_pkg::WideW-1:0] quo_o,
  output logic [rar_pkg::DenW-1:0]  rem_o
);
  import rar_pkg::*;

  logic             run_q;
  logic             done_q;
  logic [6:0]       cnt_q;
  logic [WideW-1:0] n_q;
  logic [DenW-1:0]  d_q;
  logic [DenW-1:0]  r_q;
  logic [DenW:0]    trial;
  logic             ge;
  logic [DenW:0]    diff;

  always_comb begin
    trial = {r_q, n_q[WideW-1]};
    ge    = trial >= {1'b0, d_q};
    diff  = trial - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= dividend_i;
      d_q <= divisor_i;
      r_q <= '0;
    end else if (run_q) begin
      n_q <= {n_q[WideW-2:0], ge};
      r_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;
  assign rem_o  = r_q;

endmodule

// ===== hw/rtl/rar_mul.sv =====
module rar_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rar_pkg::WordW-1:0] a_i,
  input  logic [rar_pkg::WordW-1:0] b_i,
  output logic                     done_o,
  output logic [rar_pkg::WideW-1:0] prod_o
);
  import rar_pkg::*;

  logic             run_q;
  logic             done_q;
  logic [2:0]       cnt_q;
  logic [WordW-1:0] a_q;
  logic [WordW-1:0] b_q;
  logic [WordW-1:0] part_q;
  logic [1:0]       sh_q;
  logic [WideW-1:0] acc_q;
  logic [31:0]      a_part;
  logic [31:0]      b_part;
  logic [WideW-1:0] term;

  always_comb begin
    a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    case (sh_q)
      2'd0:    term = {64'd0, part_q};
      2'd1:    term = {32'd0, part_q, 32'd0};
      2'd2:    term = {part_q, 64'd0};
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q != 3'd0) acc_q <= acc_q + term;
      if (cnt_q < 3'd4) begin
        part_q <= a_part * b_part;
        sh_q   <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/rational_add_reduced_top.sv =====
// channel  | direction | handshake            | fields
// ---------+-----------+----------------------+------------------------------------------
// operands | in        | start_i, busy_o      | first_num/den, second_num/den
// sum      | out       | valid_o (1 cycle)    | sum_negative, sum_num_high/low, sum_den_high/low
//
// One transfer in, one result out, one item at a time; busy_o is high from accept until the
// result cycle. Cost is set by the shared units: binary gcd (1 step/cycle), a 128-bit
// restoring divider and a 32x32 multiplier used for 64x64 products.
// Pass-through sums go from the dispatch state straight to the result state.
// Reset returns to idle; results cannot stall.
module rational_add_reduced_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rar_pkg::NumW-1:0]     first_num_i,
  input  logic [rar_pkg::DenW-1:0]     first_den_i,
  input  logic [rar_pkg::NumW-1:0]     second_num_i,
  input  logic [rar_pkg::DenW-1:0]     second_den_i,
  output logic                        valid_o,
  output logic                        sum_negative_o,
  output logic [rar_pkg::NumHighW-1:0] sum_num_high_o,
  output logic [rar_pkg::WordW-1:0]    sum_num_low_o,
  output logic [rar_pkg::DenHighW-1:0] sum_den_high_o,
  output logic [rar_pkg::WordW-1:0]    sum_den_low_o
);
  import rar_pkg::*;

  localparam logic [5:0] S_IDLE = 6'd0,  S_DISP = 6'd1,  S_EQ_G = 6'd2,  S_EQ_GW = 6'd3;
  localparam logic [5:0] S_EQ_D1 = 6'd4, S_EQ_D1W = 6'd5, S_EQ_D2 = 6'd6, S_EQ_D2W = 6'd7;
  localparam logic [5:0] S_M1W = 6'd8,   S_M2W = 6'd9,   S_GW = 6'd10;
  localparam logic [5:0] S_C1 = 6'd11,   S_C1W = 6'd12,  S_C2 = 6'd13,  S_C2W = 6'd14;
  localparam logic [5:0] S_C3 = 6'd15,   S_C3W = 6'd16;
  localparam logic [5:0] S_G1 = 6'd17,   S_G1W = 6'd18,  S_G2 = 6'd19,  S_G2W = 6'd20;
  localparam logic [5:0] S_G3 = 6'd21,   S_G3W = 6'd22,  S_G4 = 6'd23,  S_G4W = 6'd24;
  localparam logic [5:0] S_G5 = 6'd25,   S_G5W = 6'd26,  S_G6 = 6'd27,  S_G6W = 6'd28;
  localparam logic [5:0] S_G7 = 6'd29,   S_G7W = 6'd30,  S_G8 = 6'd31,  S_G8W = 6'd32;
  localparam logic [5:0] S_G9 = 6'd33,   S_G9W = 6'd34,  S_FIN = 6'd35;

  logic [5:0]       state_q, state_d;
  logic             s1_q, s2_q, sr_q;
  logic [NumW-1:0]  pp_q, rr_q;
  logic [DenW-1:0]  q1_q, q2_q, g_q, a_q, b_q, rem_q;
  logic [WideW-1:0] n_q, d_q, x_q;

  logic             accept;
  logic [NumW-1:0]  mag1, mag2;
  logic [DenW-1:0]  den1, den2;

  logic             mul_start, mul_done;
  logic [WordW-1:0] mul_a, mul_b;
  logic [WideW-1:0] mul_p;
  logic             div_start, div_done;
  logic [WideW-1:0] div_n, div_quo;
  logic [DenW-1:0]  div_d, div_rem;
  logic             gcd_start;
  logic [WordW-1:0] gcd_a, gcd_b;

  logic             grun_q, gdone_q;
  logic [WordW-1:0] ga_q, gb_q, gres_q;
  logic [5:0]       gk_q;

  logic             add_sx, add_sy;
  logic [WideW-1:0] add_x, add_y;
  sm_t              add_r;

  logic [WideW-1:0] pp_w, rr_w, q1_w;

  assign accept = start_i && (state_q == S_IDLE);
  assign mag1   = first_num_i[NumW-1] ? (~first_num_i + 1'b1) : first_num_i;
  assign mag2   = second_num_i[NumW-1] ? (~second_num_i + 1'b1) : second_num_i;
  assign den1   = (first_den_i == '0) ? DenW'(1) : first_den_i;
  assign den2   = (second_den_i == '0) ? DenW'(1) : second_den_i;
  assign pp_w   = WideW'(pp_q);
  assign rr_w   = WideW'(rr_q);
  assign q1_w   = WideW'(q1_q);

  rar_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_p)
  );

  rar_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n), .divisor_i(div_d),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  // binary gcd, one step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grun_q  <= 1'b0;
      gdone_q <= 1'b0;
    end else begin
      gdone_q <= 1'b0;
      if (gcd_start) begin
        grun_q <= 1'b1;
      end else if (grun_q && (ga_q == '0 || gb_q == '0)) begin
        grun_q  <= 1'b0;
        gdone_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gcd_start) begin
      ga_q <= gcd_a;
      gb_q <= gcd_b;
      gk_q <= '0;
    end else if (grun_q) begin
      if (ga_q == '0) begin
        gres_q <= gb_q << gk_q;
      end else if (gb_q == '0) begin
        gres_q <= ga_q << gk_q;
      end else if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + 6'd1;
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = g_q;
    gcd_start = 1'b0;
    gcd_a     = '0;
    gcd_b     = '0;
    add_sx    = s1_q;
    add_x     = pp_w;
    add_sy    = s2_q;
    add_y     = rr_w;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DISP;
      S_DISP: begin
        if (q1_q == q2_q) begin
          state_d = (q1_q == DenW'(1)) ? S_FIN : S_EQ_G;
        end else if (pp_q == '0 || rr_q == '0) begin
          state_d = S_FIN;
        end else if (q2_q == DenW'(1)) begin
          mul_start = 1'b1;
          mul_a     = WordW'(rr_q);
          mul_b     = WordW'(q1_q);
          state_d   = S_M1W;
        end else if (q1_q == DenW'(1)) begin
          mul_start = 1'b1;
          mul_a     = WordW'(pp_q);
          mul_b     = WordW'(q2_q);
          state_d   = S_M2W;
        end else begin
          gcd_start = 1'b1;
          gcd_a     = WordW'(q1_q);
          gcd_b     = WordW'(q2_q);
          state_d   = S_GW;
        end
      end
      S_EQ_G: begin
        gcd_start = 1'b1;
        gcd_a     = n_q[WordW-1:0];
        gcd_b     = WordW'(q1_q);
        state_d   = S_EQ_GW;
      end
      S_EQ_GW: if (gdone_q) state_d = (gres_q == WordW'(1)) ? S_FIN : S_EQ_D1;
      S_EQ_D1: begin
        div_start = 1'b1;
        div_n     = n_q;
        state_d   = S_EQ_D1W;
      end
      S_EQ_D1W: if (div_done) state_d = S_EQ_D2;
      S_EQ_D2: begin
        div_start = 1'b1;
        div_n     = q1_w;
        state_d   = S_EQ_D2W;
      end
      S_EQ_D2W: if (div_done) state_d = S_FIN;
      S_M1W: begin
        add_sx = s2_q;
        add_x  = mul_p;
        add_sy = s1_q;
        add_y  = pp_w;
        if (mul_done) state_d = S_FIN;
      end
      S_M2W: begin
        add_x = mul_p;
        if (mul_done) state_d = S_FIN;
      end
      S_GW: if (gdone_q) state_d = (gres_q == WordW'(1)) ? S_C1 : S_G1;
      S_C1: begin
        mul_start = 1'b1;
        mul_a     = WordW'(pp_q);
        mul_b     = WordW'(q2_q);
        state_d   = S_C1W;
      end
      S_C1W: if (mul_done) state_d = S_C2;
      S_C2: begin
        mul_start = 1'b1;
        mul_a     = WordW'(q1_q);
        mul_b     = WordW'(rr_q);
        state_d   = S_C2W;
      end
      S_C2W: begin
        add_x = x_q;
        add_y = mul_p;
        if (mul_done) state_d = S_C3;
      end
      S_C3: begin
        mul_start = 1'b1;
        mul_a     = WordW'(q1_q);
        mul_b     = WordW'(q2_q);
        state_d   = S_C3W;
      end
      S_C3W: if (mul_done) state_d = S_FIN;
      S_G1: begin
        div_start = 1'b1;
        div_n     = q1_w;
        state_d   = S_G1W;
      end
      S_G1W: if (div_done) state_d = S_G2;
      S_G2: begin
        div_start = 1'b1;
        div_n     = WideW'(q2_q);
        state_d   = S_G2W;
      end
      S_G2W: if (div_done) state_d = S_G3;
      S_G3: begin
        mul_start = 1'b1;
        mul_a     = WordW'(pp_q);
        mul_b     = WordW'(b_q);
        state_d   = S_G3W;
      end
      S_G3W: if (mul_done) state_d = S_G4;
      S_G4: begin
        mul_start = 1'b1;
        mul_a     = WordW'(rr_q);
        mul_b     = WordW'(a_q);
        state_d   = S_G4W;
      end
      S_G4W: begin
        add_x = x_q;
        add_y = mul_p;
        if (mul_done) state_d = S_G5;
      end
      S_G5: begin
        div_start = 1'b1;
        div_n     = n_q;
        state_d   = S_G5W;
      end
      S_G5W: if (div_done) state_d = S_G6;
      S_G6: begin
        gcd_start = 1'b1;
        gcd_a     = WordW'(rem_q);
        gcd_b     = WordW'(g_q);
        state_d   = S_G6W;
      end
      S_G6W: if (gdone_q) state_d = (gres_q == WordW'(1)) ? S_G9 : S_G7;
      S_G7: begin
        div_start = 1'b1;
        div_n     = n_q;
        div_d     = a_q;
        state_d   = S_G7W;
      end
      S_G7W: if (div_done) state_d = S_G8;
      S_G8: begin
        div_start = 1'b1;
        div_n     = q1_w;
        div_d     = a_q;
        state_d   = S_G8W;
      end
      S_G8W: if (div_done) state_d = S_G9;
      S_G9: begin
        mul_start = 1'b1;
        mul_a     = WordW'(q1_q);
        mul_b     = WordW'(b_q);
        state_d   = S_G9W;
      end
      S_G9W: if (mul_done) state_d = S_FIN;
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign add_r = add_sm(add_sx, add_x, add_sy, add_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a_q is reused for h once a has been consumed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          s1_q <= first_num_i[NumW-1];
          s2_q <= second_num_i[NumW-1];
          pp_q <= mag1;
          rr_q <= mag2;
          q1_q <= den1;
          q2_q <= den2;
        end
      end
      S_DISP: begin
        if (q1_q == q2_q) begin
          sr_q <= add_r.neg;
          n_q  <= add_r.mag;
          d_q  <= q1_w;
        end else if (pp_q == '0) begin
          sr_q <= s2_q;
          n_q  <= rr_w;
          d_q  <= WideW'(q2_q);
        end else if (rr_q == '0) begin
          sr_q <= s1_q;
          n_q  <= pp_w;
          d_q  <= q1_w;
        end
      end
      S_EQ_GW: if (gdone_q) g_q <= gres_q[DenW-1:0];
      S_EQ_D1W: if (div_done) n_q <= div_quo;
      S_EQ_D2W: if (div_done) d_q <= div_quo;
      S_M1W: begin
        if (mul_done) begin
          sr_q <= add_r.neg;
          n_q  <= add_r.mag;
          d_q  <= q1_w;
        end
      end
      S_M2W: begin
        if (mul_done) begin
          sr_q <= add_r.neg;
          n_q  <= add_r.mag;
          d_q  <= WideW'(q2_q);
        end
      end
      S_GW: if (gdone_q) g_q <= gres_q[DenW-1:0];
      S_C1W, S_G3W: if (mul_done) x_q <= mul_p;
      S_C2W, S_G4W: begin
        if (mul_done) begin
          sr_q <= add_r.neg;
          n_q  <= add_r.mag;
        end
      end
      S_C3W, S_G9W: if (mul_done) d_q <= mul_p;
      S_G1W: if (div_done) a_q <= div_quo[DenW-1:0];
      S_G2W: if (div_done) b_q <= div_quo[DenW-1:0];
      S_G5W: if (div_done) rem_q <= div_rem;
      S_G6W: if (gdone_q) a_q <= gres_q[DenW-1:0];
      S_G7W: if (div_done) n_q <= div_quo;
      S_G8W: if (div_done) q1_q <= div_quo[DenW-1:0];
      default: ;
    endcase
  end

  assign busy_o         = (state_q != S_IDLE);
  assign valid_o        = (state_q == S_FIN);
  assign sum_negative_o = sr_q && (n_q != '0);
  assign sum_num_high_o = n_q[WordW+NumHighW-1:WordW];
  assign sum_num_low_o  = n_q[WordW-1:0];
  assign sum_den_high_o = d_q[WordW+DenHighW-1:WordW];
  assign sum_den_low_o  = d_q[WordW-1:0];

endmodule

// ===== hw/rtl/rar_chk.sv =====
module rar_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        valid_o,
  input logic                        sum_negative_o,
  input logic [rar_pkg::NumHighW-1:0] sum_num_high_o,
  input logic [rar_pkg::WordW-1:0]    sum_num_low_o,
  input logic [rar_pkg::DenHighW-1:0] sum_den_high_o,
  input logic [rar_pkg::WordW-1:0]    sum_den_low_o
);

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result outside busy window");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !valid_o) else $error("transfer not taken");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o && !valid_o) else $error("no return to idle after result");

  a_zero_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sum_num_high_o == '0 && sum_num_low_o == '0 |-> !sum_negative_o)
    else $error("negative zero");

  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> sum_den_high_o != '0 || sum_den_low_o != '0) else $error("zero denominator");

endmodule

bind rational_add_reduced_top rar_chk u_rar_chk (.*);

// ===== sim/rational_add_reduced_checker.sv =====
`timescale 1ns / 1ps

module rational_add_reduced_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [rar_pkg::NumW-1:0]     first_num_i,
  input  logic [rar_pkg::DenW-1:0]     first_den_i,
  input  logic [rar_pkg::NumW-1:0]     second_num_i,
  input  logic [rar_pkg::DenW-1:0]     second_den_i,
  input  logic                         valid_i,
  input  logic                         sum_negative_i,
  input  logic [rar_pkg::NumHighW-1:0] sum_num_high_i,
  input  logic [rar_pkg::WordW-1:0]    sum_num_low_i,
  input  logic [rar_pkg::DenHighW-1:0] sum_den_high_i,
  input  logic [rar_pkg::WordW-1:0]    sum_den_low_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           sums_seen_o
);
  import rar_pkg::*;

  typedef struct packed {
    logic             neg;
    logic [WideW-1:0] mag;
  } signed_mag_t;

  typedef struct packed {
    logic                neg;
    logic [NumHighW-1:0] num_high;
    logic [WordW-1:0]    num_low;
    logic [DenHighW-1:0] den_high;
    logic [WordW-1:0]    den_low;
  } reduced_sum_t;

  reduced_sum_t expected_sums[$];

  function automatic logic [WideW-1:0] euclid_gcd(input logic [WideW-1:0] a,
                                                 input logic [WideW-1:0] b);
    logic [WideW-1:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic signed_mag_t mag_add(input logic sx, input logic [WideW-1:0] x,
                                          input logic sy, input logic [WideW-1:0] y);
    signed_mag_t r;
    if (sx == sy) begin
      r.neg = sx; r.mag = x + y;
    end else if (x >= y) begin
      r.neg = sx; r.mag = x - y;
    end else begin
      r.neg = sy; r.mag = y - x;
    end
    return r;
  endfunction

  function automatic reduced_sum_t predict_sum(input logic [NumW-1:0] n1,
                                               input logic [DenW-1:0] d1,
                                               input logic [NumW-1:0] n2,
                                               input logic [DenW-1:0] d2);
    logic s1, s2;
    logic [NumW-1:0] m1, m2;
    logic [WideW-1:0] p, r, q, s, g, a, b, h, den;
    signed_mag_t n;
    reduced_sum_t res;
    s1 = n1[NumW-1];
    s2 = n2[NumW-1];
    m1 = s1 ? (~n1 + 1'b1) : n1;
    m2 = s2 ? (~n2 + 1'b1) : n2;
    p = WideW'(m1);
    r = WideW'(m2);
    q = (d1 == 0) ? 1 : WideW'(d1);
    s = (d2 == 0) ? 1 : WideW'(d2);
    if (q == s) begin
      n = mag_add(s1, p, s2, r);
      if (q != 1) begin
        g = euclid_gcd(n.mag, q);
        if (g != 1) begin
          n.mag = n.mag / g;
          q = q / g;
        end
      end
      den = q;
    end else if (p == 0) begin
      n.neg = s2; n.mag = r; den = s;
    end else if (r == 0) begin
      n.neg = s1; n.mag = p; den = q;
    end else if (s == 1) begin
      n = mag_add(s2, r * q, s1, p);
      den = q;
    end else if (q == 1) begin
      n = mag_add(s1, p * s, s2, r);
      den = s;
    end else begin
      g = euclid_gcd(q, s);
      if (g == 1) begin
        n = mag_add(s1, p * s, s2, q * r);
        den = q * s;
      end else begin
        a = q / g;
        b = s / g;
        n = mag_add(s1, p * b, s2, r * a);
        h = euclid_gcd(n.mag % g, g);
        if (h != 1) begin
          n.mag = n.mag / h;
          q = q / h;
        end
        den = q * b;
      end
    end
    if (n.mag == 0) n.neg = 1'b0;
    res.neg      = n.neg;
    res.num_high = n.mag[64 +: NumHighW];
    res.num_low  = n.mag[63:0];
    res.den_high = den[64 +: DenHighW];
    res.den_low  = den[63:0];
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    sums_seen_o  = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    reduced_sum_t want;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (start_i && !busy_i)
        expected_sums.push_back(predict_sum(first_num_i, first_den_i,
                                            second_num_i, second_den_i));
      if (valid_i) begin
        sums_seen_o <= sums_seen_o + 1;
        if (expected_sums.size() == 0) begin
          $error("sum transfer with nothing expected");
          errs++;
        end else begin
          want = expected_sums.pop_front();
          if (want.neg !== sum_negative_i) begin
            $error("sum_negative: expected %0d, got %0d", want.neg, sum_negative_i);
            errs++;
          end
          if (want.num_high !== sum_num_high_i) begin
            $error("sum_num_high: expected %0h, got %0h", want.num_high, sum_num_high_i);
            errs++;
          end
          if (want.num_low !== sum_num_low_i) begin
            $error("sum_num_low: expected %0h, got %0h", want.num_low, sum_num_low_i);
            errs++;
          end
          if (want.den_high !== sum_den_high_i) begin
            $error("sum_den_high: expected %0h, got %0h", want.den_high, sum_den_high_i);
            errs++;
          end
          if (want.den_low !== sum_den_low_i) begin
            $error("sum_den_low: expected %0h, got %0h", want.den_low, sum_den_low_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      pending_o = expected_sums.size();
    end
  end

endmodule

// ===== sim/rational_add_reduced_top_test.sv =====
`timescale 1ns / 1ps

module rational_add_reduced_top_test;
  import rar_pkg::*;

  localparam int IdleLimit   = 20000;
  localparam int RandomItems = 1530;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [NumW-1:0]        first_num, second_num;
  logic [DenW-1:0]        first_den, second_den;
  logic                   valid;
  logic                   sum_negative;
  logic [NumHighW-1:0]    sum_num_high;
  logic [WordW-1:0]       sum_num_low;
  logic [DenHighW-1:0]    sum_den_high;
  logic [WordW-1:0]       sum_den_low;
  int                     fail_count, pending, sums_seen, idle_cycles, items_sent;

  rational_add_reduced_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .first_num_i(first_num), .first_den_i(first_den),
    .second_num_i(second_num), .second_den_i(second_den),
    .valid_o(valid), .sum_negative_o(sum_negative),
    .sum_num_high_o(sum_num_high), .sum_num_low_o(sum_num_low),
    .sum_den_high_o(sum_den_high), .sum_den_low_o(sum_den_low)
  );

  rational_add_reduced_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .first_num_i(first_num), .first_den_i(first_den),
    .second_num_i(second_num), .second_den_i(second_den),
    .valid_i(valid), .sum_negative_i(sum_negative),
    .sum_num_high_i(sum_num_high), .sum_num_low_i(sum_num_low),
    .sum_den_high_i(sum_den_high), .sum_den_low_i(sum_den_low),
    .fail_count_o(fail_count), .pending_o(pending), .sums_seen_o(sums_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // value in [0, 2^bits), bits >= 1
  function automatic logic [63:0] rand_bits(input int bits);
    return rand64() & ((64'd1 << bits) - 1);
  endfunction

  function automatic logic [NumW-1:0] signed_num(input logic [63:0] mag);
    logic [NumW-1:0] m;
    m = mag[NumW-1:0];
    return $urandom_range(0, 1) ? (~m + 1'b1) : m;
  endfunction

  task automatic send_operands(input logic [NumW-1:0] n1, input logic [DenW-1:0] d1,
                               input logic [NumW-1:0] n2, input logic [DenW-1:0] d2);
    int gap;
    gap = $urandom_range(0, 9);
    if (items_sent % 200 >= 150) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    first_num  <= n1;
    first_den  <= d1;
    second_num <= n2;
    second_den <= d2;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [63:0] g, a, b, q1, q2;
    int kind, w;
    kind = $urandom_range(0, 7);
    w = $urandom_range(1, 61);
    case (kind)
      0: send_operands(NumW'(rand64()), DenW'(rand64()), NumW'(rand64()), DenW'(rand64()));
      1: send_operands(signed_num(64'($urandom_range(0, 30))), DenW'($urandom_range(0, 30)),
                       signed_num(64'($urandom_range(0, 30))), DenW'($urandom_range(0, 30)));
      2, 3: begin
        g  = 64'($urandom_range(2, 5000));
        a  = rand_bits($urandom_range(1, 40)) | 1;
        b  = rand_bits($urandom_range(1, 40)) | 1;
        q1 = g * a;
        q2 = g * b;
        send_operands(signed_num(rand_bits(w)), q1[DenW-1:0],
                      signed_num(rand_bits(w)), q2[DenW-1:0]);
      end
      4: begin
        q1 = rand_bits(w);
        send_operands(signed_num(rand_bits(w)), q1[DenW-1:0],
                      signed_num(rand_bits($urandom_range(1, 62))), q1[DenW-1:0]);
      end
      5: send_operands(signed_num(rand_bits(w)), DenW'(rand_bits(w)),
                       signed_num(rand_bits($urandom_range(1, 62))), 1);
      6: send_operands(signed_num(rand_bits(w)), 1, signed_num(rand_bits(w)),
                       DenW'(rand_bits(w)));
      default: begin
        if ($urandom_range(0, 1))
          send_operands(0, DenW'(rand_bits(w)), signed_num(rand_bits(w)),
                        DenW'(rand_bits(w)));
        else
          send_operands(signed_num(rand_bits(w)), DenW'(rand_bits(w)), 0,
                        DenW'(rand_bits(w)));
      end
    endcase
  endtask

  localparam logic [NumW-1:0] MostNeg = {1'b1, {(NumW-1){1'b0}}};
  localparam logic [NumW-1:0] MaxPos  = {1'b0, {(NumW-1){1'b1}}};
  localparam logic [DenW-1:0] MaxDen  = {DenW{1'b1}};

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    first_num = '0; first_den = '0; second_num = '0; second_den = '0;
    idle_cycles = 0;
    items_sent = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // equal denominators, with and without reduction, and a zero sum
    send_operands(3, 10, 7, 10);
    send_operands(5, 7, -5, 7);
    send_operands(MaxPos, 1, MaxPos, 1);
    send_operands(MostNeg, 1, MostNeg, 1);
    send_operands(MostNeg, MaxDen, MaxPos, MaxDen);
    // zero numerators
    send_operands(0, 5, -3, 7);
    send_operands(-4, 9, 0, 2);
    send_operands(0, 1, 0, 3);
    // integer operands
    send_operands(-7, 3, MaxPos, 1);
    send_operands(MostNeg, 1, 5, MaxDen);
    send_operands(MaxPos, MaxDen - 1, MostNeg, 1);
    // coprime denominators, extreme products
    send_operands(MaxPos, MaxDen, MostNeg, MaxDen - 1);
    send_operands(1, 2, 1, 3);
    // shared factor, with reduction by the gcd of the sum
    send_operands(1, 6, 1, 10);
    send_operands(1, 4, 1, 12);
    send_operands(-1, 6, 1, 6 * 5);
    // zero denominators read as 1
    send_operands(5, 0, 3, 0);
    send_operands(2, 0, 1, 3);
    // non-canonical operands
    send_operands(4, 6, 6, 9);
    send_operands(MostNeg, 6, MaxPos, 4);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) begin
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_random();
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d operand pairs across all addition cases, checked %0d sums",
             items_sent, sums_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rar_pkg.sv
hw/rtl/rar_div.sv
hw/rtl/rar_mul.sv
hw/rtl/rational_add_reduced_top.sv
hw/rtl/rar_chk.sv
sim/rational_add_reduced_checker.sv
sim/rational_add_reduced_top_test.sv
